FILE: rtl/bhar_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bhar_pkg: shared types and constants for the button hold auto-repeat block
// Item structs, register indexes, reset values and the fast repeat divisor.
// ----------------------------------------------------------------------------
package bhar_pkg;

  // Fast repeat: step applied on every FastRepeatDivisor-th tick (1..255)
  localparam int unsigned FastRepeatDivisor = 40;
  localparam int unsigned SkipModW = (FastRepeatDivisor > 1) ? $clog2(FastRepeatDivisor) : 1;
  localparam logic [SkipModW-1:0] SkipModLast = SkipModW'(FastRepeatDivisor - 1);

  // Configuration port
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegDebounce   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegShortPress = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegLongPress  = CfgIdxW'(2);

  localparam logic [15:0] DebounceRst   = 16'd10;
  localparam logic [15:0] ShortPressRst = 16'd300;
  localparam logic [15:0] LongPressRst  = 16'd900;

  // One input item per millisecond tick
  typedef struct packed {
    logic               pressed;
    logic        [31:0] now_ms;
    logic signed [7:0]  step;
    logic signed [15:0] value_in;
  } in_t;

  // One result item per tick
  typedef struct packed {
    logic signed [15:0] value_out;
    logic               active;
    logic               beep;
  } out_t;

endpackage
`default_nettype wire

FILE: rtl/button_hold_auto_repeat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// button_hold_auto_repeat: debounced button with short-press step and fast repeat
// Per tick, updates bounce/hold start times and adjusts a 16-bit value.
// ----------------------------------------------------------------------------
// Each accepted item is one millisecond tick and yields exactly one result item,
// which leaves from the result register. A new item is taken every cycle unless
// the skid entry is full; the tick's state update (start times, skip counter) is
// a single compare-and-add pass at the input, and a two-entry result buffer
// (output register plus skid) keeps input accepting for one more item while a
// result waits downstream. A start time of zero means empty; elapsed times wrap
// modulo 2^32 and are compared strictly greater than the configured limits.
// Configuration writes are always accepted and take effect on the next tick.
module button_hold_auto_repeat (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // tick input
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire bhar_pkg::in_t                 in_data_i,
  // result output
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      bhar_pkg::out_t                out_data_o,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [bhar_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i
);

  // Configuration registers
  logic [15:0] debounce_q, short_q, long_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= bhar_pkg::DebounceRst;
      short_q    <= bhar_pkg::ShortPressRst;
      long_q     <= bhar_pkg::LongPressRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bhar_pkg::RegDebounce:   debounce_q <= cfg_data_i;
        bhar_pkg::RegShortPress: short_q    <= cfg_data_i;
        bhar_pkg::RegLongPress:  long_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Tick state
  logic [31:0]                   bounce_q, bounce_d;
  logic [31:0]                   hold_q, hold_d;
  logic [7:0]                    skip_q, skip_d;
  logic [bhar_pkg::SkipModW-1:0] skip_mod_q, skip_mod_d;

  logic           push;
  bhar_pkg::out_t res;

  logic [31:0] bounce_eff, hold_eff;
  logic [31:0] hold_el, bounce_el, active_el;
  logic [15:0] step_ext;

  // One tick: start times, repeat decision, debounce
  always_comb begin
    bounce_eff = (bounce_q == 32'd0) ? in_data_i.now_ms : bounce_q;
    hold_eff   = (hold_q == 32'd0) ? bounce_eff : hold_q;
    hold_el    = in_data_i.now_ms - hold_eff;
    bounce_el  = in_data_i.now_ms - bounce_eff;
    step_ext   = {{8{in_data_i.step[7]}}, in_data_i.step};

    bounce_d      = bounce_q;
    hold_d        = hold_q;
    skip_d        = skip_q;
    skip_mod_d    = skip_mod_q;
    res.value_out = in_data_i.value_in;
    res.beep      = 1'b0;
    res.active    = 1'b0;

    if (in_data_i.pressed) begin
      bounce_d = bounce_eff;
      hold_d   = hold_eff;
      if (hold_el > {16'd0, long_q}) begin
        // fast repeat: step when the counter sits on a multiple of the divisor
        if (skip_mod_q == '0) begin
          res.value_out = in_data_i.value_in + step_ext;
        end
        skip_d = skip_q + 8'd1;
        // counter wraps at 256, so its residue restarts there too
        if (skip_q == 8'hFF || skip_mod_q == bhar_pkg::SkipModLast) begin
          skip_mod_d = '0;
        end else begin
          skip_mod_d = skip_mod_q + bhar_pkg::SkipModW'(1);
        end
      end else if (bounce_el > {16'd0, short_q}) begin
        res.value_out = in_data_i.value_in + step_ext;
        bounce_d      = 32'd0;
        res.beep      = 1'b1;
      end
    end else begin
      bounce_d = 32'd0;
      hold_d   = 32'd0;
    end

    active_el  = in_data_i.now_ms - bounce_d;
    res.active = in_data_i.pressed && (active_el > {16'd0, debounce_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_q   <= 32'd0;
      hold_q     <= 32'd0;
      skip_q     <= 8'd0;
      skip_mod_q <= '0;
    end else if (push) begin
      bounce_q   <= bounce_d;
      hold_q     <= hold_d;
      skip_q     <= skip_d;
      skip_mod_q <= skip_mod_d;
    end
  end

  // Result buffer: output register plus one skid entry
  logic           out_valid_q, skid_valid_q;
  bhar_pkg::out_t out_q, skid_q;
  logic           pop;

  assign in_ready_o  = !skid_valid_q;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

endmodule
`default_nettype wire

FILE: dv/bhar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhar_checker: result predictor and scoreboard for button_hold_auto_repeat
// Watches the tick, result and configuration channels. It keeps its own copy
// of the start times, skip counter and limits, predicts one result per
// accepted tick and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module bhar_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  bhar_pkg::in_t                in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  bhar_pkg::out_t               out_data_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [bhar_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                  cfg_data_i,
  output int unsigned                  err_cnt_o,
  output int unsigned                  pending_o
);

  // Shadow limits and tick state
  logic [15:0] debounce_lim;
  logic [15:0] short_lim;
  logic [15:0] long_lim;
  logic [31:0] bounce_start;
  logic [31:0] hold_start;
  logic [7:0]  skip_count;

  bhar_pkg::out_t due_results[$];
  int unsigned    result_idx;

  task automatic report_mismatch(input string msg);
    $display("[%0t] check: %s", $time, msg);
    err_cnt_o++;
  endtask

  // Advance the shadow state by one tick and return the result it yields
  function automatic bhar_pkg::out_t apply_tick(input bhar_pkg::in_t t);
    bhar_pkg::out_t     r;
    logic signed [15:0] inc;
    logic [31:0]        held_for;
    logic [31:0]        bounced_for;
    r.value_out = t.value_in;
    r.active    = 1'b0;
    r.beep      = 1'b0;
    inc         = {{8{t.step[7]}}, t.step};
    if (t.pressed) begin
      // a start time of zero counts as empty and is taken again
      if (bounce_start == '0) bounce_start = t.now_ms;
      if (hold_start == '0) hold_start = bounce_start;
      held_for    = t.now_ms - hold_start;
      bounced_for = t.now_ms - bounce_start;
      if (held_for > {16'h0, long_lim}) begin
        // fast repeat: step only on every divisor-th tick
        if (skip_count % bhar_pkg::FastRepeatDivisor == 0)
          r.value_out = r.value_out + inc;
        skip_count = skip_count + 8'd1;
      end else if (bounced_for > {16'h0, short_lim}) begin
        r.value_out  = r.value_out + inc;
        bounce_start = '0;
        r.beep       = 1'b1;
      end
      // debounce uses the bounce start as it stands now (may be cleared)
      if (t.now_ms - bounce_start > {16'h0, debounce_lim}) r.active = 1'b1;
    end else begin
      bounce_start = '0;
      hold_start   = '0;
    end
    return r;
  endfunction

  // Compare results first: a tick's result never leaves on its own edge
  always @(posedge clk_i or negedge rst_ni) begin
    bhar_pkg::out_t want;
    if (!rst_ni) begin
      debounce_lim = bhar_pkg::DebounceRst;
      short_lim    = bhar_pkg::ShortPressRst;
      long_lim     = bhar_pkg::LongPressRst;
      bounce_start = '0;
      hold_start   = '0;
      skip_count   = '0;
      due_results.delete();
      result_idx   = 0;
      err_cnt_o    = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no tick waiting", result_idx));
        end else begin
          want = due_results.pop_front();
          if (out_data_i.value_out !== want.value_out)
            report_mismatch($sformatf("result %0d value_out %0d, want %0d", result_idx,
                                      out_data_i.value_out, want.value_out));
          if (out_data_i.active !== want.active)
            report_mismatch($sformatf("result %0d active %b, want %b", result_idx,
                                      out_data_i.active, want.active));
          if (out_data_i.beep !== want.beep)
            report_mismatch($sformatf("result %0d beep %b, want %b", result_idx,
                                      out_data_i.beep, want.beep));
        end
        result_idx++;
      end
      if (in_valid_i && in_ready_i) due_results.push_back(apply_tick(in_data_i));
      // register writes apply from the next tick on
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          bhar_pkg::RegDebounce:   debounce_lim = cfg_data_i;
          bhar_pkg::RegShortPress: short_lim    = cfg_data_i;
          bhar_pkg::RegLongPress:  long_lim     = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = due_results.size();
    end
  end

endmodule

FILE: dv/tb_button_hold_auto_repeat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_hold_auto_repeat: stimulus and verdict for button_hold_auto_repeat
// Drives directed ticks, then random press and release sequences with chatter
// and time jumps under several limit settings and idling mixes. Prediction
// and comparison live in bhar_checker.
// ----------------------------------------------------------------------------
module tb_button_hold_auto_repeat;

  localparam int unsigned StallLimit = 3000;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_ready_o;
  bhar_pkg::in_t                in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  bhar_pkg::out_t               out_data_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [bhar_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [15:0]                  cfg_data_i  = '0;

  int unsigned err_cnt;
  int unsigned pending;
  int unsigned src_idle_pct  = 20;
  int unsigned sink_idle_pct = 87;
  int unsigned ticks_sent    = 0;
  int unsigned idle_cycles   = 0;
  logic        hold_off      = 1'b0;

  // Button model for the random part
  logic [31:0] clock_ms = '0;
  logic        btn_down = 1'b0;
  int          run_left = 0;

  button_hold_auto_repeat uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  bhar_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    wait (ticks_sent == 300);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (50) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Watchdog: cycles with no item moving on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("button_hold_auto_repeat: mismatch");
      $finish;
    end
  end

  // Offer one tick, with random gaps ahead of it; returns on acceptance
  task automatic send_tick(input bhar_pkg::in_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
  endtask

  task automatic tick(input logic pressed, input logic [31:0] now,
                      input logic signed [7:0] step, input logic signed [15:0] value);
    bhar_pkg::in_t t;
    t.pressed  = pressed;
    t.now_ms   = now;
    t.step     = step;
    t.value_in = value;
    send_tick(t);
  endtask

  // Stop offering and wait until every result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Write all three limits back to back; only called while drained
  task automatic set_limits(input logic [15:0] deb, input logic [15:0] sp,
                            input logic [15:0] lp);
    logic [bhar_pkg::CfgIdxW-1:0] idx [3];
    logic [15:0]                  val [3];
    idx = '{bhar_pkg::RegDebounce, bhar_pkg::RegShortPress, bhar_pkg::RegLongPress};
    val = '{deb, sp, lp};
    for (int r = 0; r < 3; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[r];
      cfg_data_i  <= val[r];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Press/release runs with random content, contact chatter and time jumps
  task automatic random_ticks(input int count, input int max_hold);
    int            roll;
    bhar_pkg::in_t t;
    for (int k = 0; k < count; k++) begin
      if (run_left == 0) begin
        btn_down = !btn_down;
        run_left = btn_down ? $urandom_range(max_hold, 1) : $urandom_range(4, 1);
      end
      run_left--;
      roll = $urandom_range(99);
      if (roll < 84) clock_ms = clock_ms + 1;
      else if (roll < 92) clock_ms = clock_ms + $urandom_range(3);
      else if (roll < 97) clock_ms = clock_ms + $urandom_range(70000);
      else if (roll < 99) clock_ms = $urandom();
      else clock_ms = '0;
      t.pressed  = btn_down ^ ($urandom_range(99) < 4);
      t.now_ms   = clock_ms;
      t.step     = 8'($urandom());
      t.value_in = 16'($urandom());
      send_tick(t);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks at reset limits (10 / 300 / 900)
    tick(1'b0, 32'd0, 8'sd127, 16'sd32767);
    tick(1'b1, 32'd0, 8'sd127, 16'sd32767);      // start at time zero reads empty
    tick(1'b1, 32'd0, 8'sd127, 16'sd32767);
    tick(1'b1, 32'd5, 8'sd127, 16'sd32767);
    tick(1'b1, 32'd15, 8'sd127, 16'sd32767);     // exactly at debounce: not active
    tick(1'b1, 32'd16, 8'sd127, 16'sd32767);
    tick(1'b1, 32'd306, 8'sd127, 16'sd32767);    // short-press step, wraps, beep
    tick(1'b1, 32'd905, -8'sd128, -16'sd32768);  // held exactly long limit
    tick(1'b1, 32'd1000, -8'sd128, -16'sd32768); // fast repeat, wraps
    tick(1'b1, 32'd1001, -8'sd128, -16'sd32768);
    tick(1'b0, 32'd1002, 8'sd1, 16'sd0);
    tick(1'b1, 32'hFFFF_FFF0, 8'sd1, 16'sd0);
    tick(1'b1, 32'h0000_0400, -8'sd1, 16'sd100); // elapsed across wrap
    tick(1'b0, 32'hFFFF_FFFF, -8'sd1, -16'sd32768);
    wait_drained();

    set_limits(16'd3, 16'd10, 16'd30);
    random_ticks(150, 120);
    wait_drained();

    src_idle_pct  = 87;
    sink_idle_pct = 20;
    set_limits(16'd0, 16'd0, 16'd0);
    random_ticks(40, 20);
    wait_drained();
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_ticks(40, 40);
    wait_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_limits(16'($urandom_range(20)), 16'($urandom_range(60)),
               16'($urandom_range(150)));
    random_ticks(110, 150);
    wait_drained();
    set_limits(16'd1, 16'd5, 16'd8);
    random_ticks(100, 100);
    wait_drained();

    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("button_hold_auto_repeat: match");
    end else begin
      $display("button_hold_auto_repeat: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/bhar_pkg.sv
rtl/button_hold_auto_repeat.sv
dv/bhar_checker.sv
dv/tb_button_hold_auto_repeat.sv
